// ----- design/sod_pkg.sv -----
// ----------------------------------------------------------------------------
// sod_pkg
// Types and constants shared by the send-on-delta report filter modules.
// ----------------------------------------------------------------------------
package sod_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int CFG_CH_COUNT     = 4;

    localparam int SAMPLE_W = 32;
    localparam int TIME_W   = 32;
    localparam int DELTA_W  = 31;
    localparam int CH_W     = 2;

    typedef logic [CH_W-1:0]     t_channel;
    typedef logic [SAMPLE_W-1:0] t_value;
    typedef logic [TIME_W-1:0]   t_time;
    typedef logic [DELTA_W-1:0]  t_delta;
    typedef logic [2:0]          t_cfg_index;

    localparam t_channel CH_TEMP  = 2'd0;
    localparam t_channel CH_HUMID = 2'd1;
    localparam t_channel CH_LIGHT = 2'd2;
    localparam t_channel CH_PRESS = 2'd3;

    localparam t_cfg_index CFG_HB_BASE = 3'd4;

    localparam t_value ONE_Q8 = 32'sd256;
    localparam t_time  TIME_MAX = '1;

    localparam t_delta DELTA_RESET [CFG_CH_COUNT] = '{31'd51, 31'd1280, 31'd6400, 31'd5120};
    localparam t_time  HEARTBEAT_RESET = 32'd900000;

    typedef struct packed {
        logic   update;
        t_value value;
        t_time  deadline;
    } t_decision;

endpackage

// ----- design/sod_eval.sv -----
// ----------------------------------------------------------------------------
// sod_eval
// Report decision for one sample against its channel's stored entry.
// ----------------------------------------------------------------------------
module sod_eval #(
    parameter int NUM_CHANNELS = sod_pkg::NUM_CHANNELS_DEF
) (
    input  sod_pkg::t_channel  i_channel,
    input  sod_pkg::t_value    i_sample,
    input  sod_pkg::t_time     i_now_ms,
    input  logic               i_altitude_ok,
    input  sod_pkg::t_value    i_last,
    input  sod_pkg::t_time     i_deadline,
    input  sod_pkg::t_delta    i_delta,
    input  sod_pkg::t_time     i_heartbeat,
    output sod_pkg::t_decision o_decision
);
    import sod_pkg::*;

    logic            in_range;
    logic            is_light;
    t_value          value;
    logic [32:0]     diff;
    logic [31:0]     mag;
    logic            fire;
    logic [32:0]     dl_sum;

    always_comb begin
        in_range = (32'(i_channel) < NUM_CHANNELS);
        is_light = (i_channel == CH_LIGHT);
        value    = (is_light && ($signed(i_sample) < $signed(ONE_Q8))) ? '0 : i_sample;
        diff     = {value[31], value} - {i_last[31], i_last};
        mag      = diff[32] ? 32'(-diff) : diff[31:0];
        fire     = (mag >= {1'b0, i_delta}) || (i_deadline < i_now_ms);
        if (is_light) begin
            if ((value == '0) && (i_last != '0)) begin
                fire = 1'b1;
            end
            if (($signed(value) > $signed(ONE_Q8)) && (i_last == '0)) begin
                fire = 1'b1;
            end
        end
        dl_sum = {1'b0, i_now_ms} + {1'b0, i_heartbeat};

        o_decision.update   = in_range && fire && !((i_channel == CH_PRESS) && !i_altitude_ok);
        o_decision.value    = value;
        o_decision.deadline = dl_sum[32] ? TIME_MAX : dl_sum[31:0];
    end

endmodule

// ----- design/send_on_delta_report_filter.sv -----
// ----------------------------------------------------------------------------
// send_on_delta_report_filter
// Send-on-delta filter with heartbeat timeout over per-channel sensor samples.
//
//   Channel   Direction  Fields
//   s_axis    in         tuser: channel; tdata: sample, now_ms, altitude_ok, altitude
//   m_axis    out        tuser: out_channel; tdata: report_value, out_altitude
//   i_cfg_*   in         register index, write data
//
// One item per cycle while the output is free; the edge that accepts an item reads the state memory,
// and when stage 1 advances the decision is taken, written back and loaded into the output register.
// A write to the entry being read in the same cycle is forwarded.
// Reset clears the per-entry valid bits, so every entry reads as zero.
// A report that cannot enter a full output register stalls the input.
// ----------------------------------------------------------------------------
module send_on_delta_report_filter #(
    parameter int NUM_CHANNELS = sod_pkg::NUM_CHANNELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // tdata: sample[31:0], now_ms[63:32], altitude_ok[64], altitude[96:65], zero pad
    input  logic [103:0]        s_axis_tdata,
    // tuser: channel[1:0]
    input  sod_pkg::t_channel   s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // tdata: report_value[31:0], out_altitude[63:32]
    output logic [63:0]         m_axis_tdata,
    // tuser: out_channel[1:0]
    output sod_pkg::t_channel   m_axis_tuser,
    input  logic                i_cfg_we,
    input  sod_pkg::t_cfg_index i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import sod_pkg::*;

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    t_delta r_delta [CFG_CH_COUNT];
    t_time  r_heartbeat [CFG_CH_COUNT];

    logic [63:0]   r_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_valid;
    logic [63:0]   r_rd_data;
    logic          r_rd_valid;
    logic          r_byp_hit;
    logic [63:0]   r_byp_data;

    logic          r_s1_valid;
    t_channel      r_s1_channel;
    t_value        r_s1_sample;
    t_time         r_s1_now;
    logic          r_s1_alt_ok;
    t_value        r_s1_altitude;

    logic          r_out_valid;
    t_channel      r_out_channel;
    t_value        r_out_value;
    t_value        r_out_altitude;

    logic          accept;
    logic          out_free;
    logic          s1_advance;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [31:0]   in_ch_ext;
    logic [31:0]   s1_ch_ext;
    logic [63:0]   entry;
    logic [63:0]   wr_data;
    t_decision     decision;

    always_comb begin
        in_ch_ext  = 32'(s_axis_tuser);
        s1_ch_ext  = 32'(r_s1_channel);
        rd_addr    = (in_ch_ext < NUM_CHANNELS) ? in_ch_ext[AW-1:0] : '0;
        wr_addr    = s1_ch_ext[AW-1:0];
        entry      = r_byp_hit ? r_byp_data : (r_rd_valid ? r_rd_data : '0);
        out_free   = !r_out_valid || m_axis_tready;
        s1_advance = r_s1_valid && (!decision.update || out_free);
        wr_en      = s1_advance && decision.update;
        wr_data    = {decision.deadline, decision.value};
        s_axis_tready = !r_s1_valid || s1_advance;
        accept     = s_axis_tvalid && s_axis_tready;
    end

    sod_eval #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_eval (
        .i_channel     (r_s1_channel),
        .i_sample      (r_s1_sample),
        .i_now_ms      (r_s1_now),
        .i_altitude_ok (r_s1_alt_ok),
        .i_last        (entry[31:0]),
        .i_deadline    (entry[63:32]),
        .i_delta       (r_delta[r_s1_channel]),
        .i_heartbeat   (r_heartbeat[r_s1_channel]),
        .o_decision    (decision)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_CH_COUNT; i++) begin
                r_delta[i]     <= DELTA_RESET[i];
                r_heartbeat[i] <= HEARTBEAT_RESET;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index < CFG_HB_BASE) begin
                r_delta[i_cfg_index[1:0]] <= i_cfg_data[DELTA_W-1:0];
            end else begin
                r_heartbeat[i_cfg_index[1:0]] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (accept) begin
            r_rd_data  <= r_mem[rd_addr];
            r_rd_valid <= r_valid[rd_addr];
            r_byp_hit  <= wr_en && (wr_addr == rd_addr);
            r_byp_data <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_channel  <= s_axis_tuser;
            r_s1_sample   <= s_axis_tdata[31:0];
            r_s1_now      <= s_axis_tdata[63:32];
            r_s1_alt_ok   <= s_axis_tdata[64];
            r_s1_altitude <= s_axis_tdata[96:65];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (wr_en) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_out_channel  <= r_s1_channel;
            r_out_value    <= decision.value;
            r_out_altitude <= (r_s1_channel == CH_PRESS) ? r_s1_altitude : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_channel;
    assign m_axis_tdata  = {r_out_altitude, r_out_value};

endmodule

// ----- tb/send_on_delta_report_filter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// send_on_delta_report_filter_tb
// Self-checking bench for the send-on-delta report filter. A scoreboard keeps
// its own copy of the thresholds, heartbeats, last reports and deadlines,
// predicts the report for every accepted sample and compares each report
// leaving the block, in order. Directed samples cover the corner cases, then
// random samples near and across the thresholds run under four register
// settings, with random gaps on both sides in all but one, and one long output stall.
// ----------------------------------------------------------------------------
module send_on_delta_report_filter_tb;

    import sod_pkg::*;

    localparam int NCH          = NUM_CHANNELS_DEF;
    localparam int QUIET_LIMIT  = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;

    typedef struct {
        t_channel channel;
        t_value   value;
        t_value   altitude;
    } t_report;

    class report_scoreboard;
        t_delta  delta_thr [NCH];
        t_time   heartbeat_ms [NCH];
        t_value  last_value [NCH];
        t_time   next_deadline [NCH];
        t_report pending_reports [$];
        int      errors;

        function new();
            for (int c = 0; c < NCH; c++) begin
                delta_thr[c]     = DELTA_RESET[c];
                heartbeat_ms[c]  = HEARTBEAT_RESET;
                last_value[c]    = '0;
                next_deadline[c] = '0;
            end
            errors = 0;
        endfunction

        function void set_reg(t_cfg_index idx, logic [31:0] data);
            if (idx < CFG_HB_BASE) begin
                delta_thr[idx] = data[DELTA_W-1:0];
            end else begin
                heartbeat_ms[idx - CFG_HB_BASE] = data;
            end
        endfunction

        function void note_sample(t_channel ch, t_value smp, t_time now_ms,
                                  logic alt_ok, t_value alt);
            longint        val;
            longint        prev;
            longint        delta_abs;
            logic          fire;
            logic [TIME_W:0] sum;
            t_report       r;
            val = longint'($signed(smp));
            if (ch == CH_LIGHT && val < longint'(ONE_Q8)) begin
                val = 0;
            end
            prev = longint'($signed(last_value[ch]));
            delta_abs = val - prev;
            if (delta_abs < 0) begin
                delta_abs = -delta_abs;
            end
            fire = (delta_abs >= longint'(delta_thr[ch])) || (next_deadline[ch] < now_ms);
            if (ch == CH_LIGHT) begin
                if (val == 0 && prev != 0) begin
                    fire = 1'b1;
                end
                if (val > longint'(ONE_Q8) && prev == 0) begin
                    fire = 1'b1;
                end
            end
            if (!fire || (ch == CH_PRESS && !alt_ok)) begin
                return;
            end
            last_value[ch] = val[31:0];
            sum = {1'b0, now_ms} + {1'b0, heartbeat_ms[ch]};
            next_deadline[ch] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
            r.channel  = ch;
            r.value    = val[31:0];
            r.altitude = (ch == CH_PRESS) ? alt : '0;
            pending_reports.push_back(r);
        endfunction

        function void check_report(t_channel ch, t_value val, t_value alt);
            t_report e;
            if (pending_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected report, channel %0d value %h altitude %h",
                         $time, ch, val, alt);
                return;
            end
            e = pending_reports.pop_front();
            if (ch !== e.channel) begin
                errors++;
                $display("%0t: channel mismatch, expected %0d actual %0d",
                         $time, e.channel, ch);
            end
            if (val !== e.value) begin
                errors++;
                $display("%0t: value mismatch, expected %h actual %h", $time, e.value, val);
            end
            if (alt !== e.altitude) begin
                errors++;
                $display("%0t: altitude mismatch, expected %h actual %h",
                         $time, e.altitude, alt);
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    t_channel     s_axis_tuser = CH_TEMP;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;
    t_channel     m_axis_tuser;
    logic         i_cfg_we = 1'b0;
    t_cfg_index   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    report_scoreboard sb = new();

    bit          gaps_on = 1'b1;
    bit          hold_req = 1'b0;
    int          quiet_cycles = 0;
    t_time       clock_ms = '0;
    logic [31:0] delta_set [NCH];
    logic [31:0] heartbeat_set [NCH];

    send_on_delta_report_filter dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_sample(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                               s_axis_tdata[64], s_axis_tdata[96:65]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_report(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32]);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Output side: random back-pressure, plus one long stall on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= gaps_on ? ($urandom_range(99) >= 25) : 1'b1;
            end
        end
    end

    task automatic send_sample(t_channel ch, t_value smp, t_time now_ms,
                               logic alt_ok, t_value alt);
        if (gaps_on) begin
            while ($urandom_range(99) < 25) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= ch;
        s_axis_tdata  <= {7'b0, alt, alt_ok, now_ms, smp};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic random_sample();
        t_channel ch;
        longint   base;
        longint   off;
        longint   d;
        longint   span;
        int       k;
        t_value   smp;
        ch = t_channel'($urandom_range(NCH - 1));
        k = $urandom_range(99);
        if (k < 10) begin
            clock_ms = sb.next_deadline[ch] + $urandom_range(2) - 1;
        end else if (k < 15) begin
            clock_ms = $urandom;
        end else begin
            clock_ms = clock_ms + $urandom_range(4000);
        end
        base = longint'($signed(sb.last_value[ch]));
        d    = longint'(sb.delta_thr[ch]);
        k    = $urandom_range(99);
        if (k < 35) begin
            span = (d > 1000000) ? 1000000 : d;
            off  = longint'($urandom_range(0, int'(2 * span)));
            if ($urandom_range(1)) off = -off;
            smp = t_value'(base + off);
        end else if (k < 55) begin
            off = d + longint'($urandom_range(2)) - 1;
            if ($urandom_range(1)) off = -off;
            smp = t_value'(base + off);
        end else if (k < 70) begin
            case ($urandom_range(4))
                0:       smp = '0;
                1:       smp = ONE_Q8 - 1;
                2:       smp = ONE_Q8;
                3:       smp = ONE_Q8 + 1;
                default: smp = '1;
            endcase
        end else begin
            smp = $urandom;
        end
        send_sample(ch, smp, clock_ms, $urandom_range(99) < 85, $urandom);
    endtask

    task automatic run_random(int count, int hold_at);
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) hold_req = 1'b1;
            random_sample();
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs();
        t_cfg_index idx;
        for (int c = 0; c < 2 * NCH; c++) begin
            idx = t_cfg_index'(c);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= (idx < CFG_HB_BASE) ? delta_set[c] : heartbeat_set[idx - CFG_HB_BASE];
            @(posedge i_clk);
            sb.set_reg(idx, (idx < CFG_HB_BASE) ? delta_set[c] : heartbeat_set[idx - CFG_HB_BASE]);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Temperature: deadline equal to now, exact threshold, full-scale swings.
        send_sample(CH_TEMP, 32'd0, 32'd0, 1'b1, 32'h0);
        send_sample(CH_TEMP, 32'd51, 32'd0, 1'b1, 32'h0);
        send_sample(CH_TEMP, 32'd101, 32'd10, 1'b0, 32'hFFFFFFFF);
        send_sample(CH_TEMP, 32'd51, 32'd900000, 1'b1, 32'h0);
        send_sample(CH_TEMP, 32'd51, 32'd900001, 1'b1, 32'h0);
        send_sample(CH_TEMP, 32'h80000000, 32'd900002, 1'b1, 32'h0);
        send_sample(CH_TEMP, 32'h7FFFFFFF, 32'd900003, 1'b1, 32'h0);
        send_sample(CH_HUMID, -32'sd1280, 32'd0, 1'b1, 32'h0);
        // Illuminance clamp and the zero edges.
        send_sample(CH_LIGHT, 32'd300, 32'd0, 1'b1, 32'h0);
        send_sample(CH_LIGHT, 32'd255, 32'd1, 1'b1, 32'h0);
        send_sample(CH_LIGHT, 32'd256, 32'd2, 1'b1, 32'h0);
        send_sample(CH_LIGHT, 32'd257, 32'd3, 1'b1, 32'h0);
        send_sample(CH_LIGHT, -32'sd5, 32'd4, 1'b1, 32'h0);
        send_sample(CH_LIGHT, 32'h80000000, 32'd5, 1'b1, 32'h0);
        send_sample(CH_LIGHT, 32'h7FFFFFFF, 32'd6, 1'b1, 32'h0);
        // Pressure: invalid altitude drops the report, then deadline saturation.
        send_sample(CH_PRESS, 32'd10000, 32'd0, 1'b0, 32'h12345678);
        send_sample(CH_PRESS, 32'd10000, 32'd1, 1'b1, 32'h80000000);
        send_sample(CH_PRESS, 32'd10000, 32'd1, 1'b1, 32'h55555555);
        send_sample(CH_PRESS, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h7FFFFFFF);
        send_sample(CH_PRESS, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hAAAAAAAA);
        send_sample(CH_HUMID, 32'd0, 32'hFFFFFFFF, 1'b1, 32'h0);
        send_sample(CH_HUMID, 32'd0, 32'hFFFFFFFF, 1'b1, 32'h0);
        clock_ms = 32'd1000;
        run_random(120, -1);
        drain();

        // Tight thresholds and short heartbeats, with no gaps on either side.
        delta_set     = '{32'd0, 32'd1, 32'd300, 32'd100};
        heartbeat_set = '{32'd0, 32'd1, 32'd5000, 32'd20000};
        program_regs();
        gaps_on = 1'b0;
        run_random(120, -1);
        drain();
        gaps_on = 1'b1;

        // Largest thresholds; the top bit of the write data must be dropped.
        delta_set     = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF};
        heartbeat_set = '{32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF, 32'd0};
        program_regs();
        run_random(120, -1);
        drain();

        for (int c = 0; c < NCH; c++) begin
            delta_set[c]     = $urandom_range(4000);
            heartbeat_set[c] = $urandom_range(50000);
        end
        program_regs();
        run_random(140, 40);
        drain();

        if (sb.errors == 0 && sb.pending_reports.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/sod_pkg.sv
design/sod_eval.sv
design/send_on_delta_report_filter.sv
tb/send_on_delta_report_filter_tb.sv
